[design/wear_leveling_table_core_macros.svh]
// Assertion macros for the wear leveling table checker
`ifndef WEAR_LEVELING_TABLE_CORE_MACROS_SVH
`define WEAR_LEVELING_TABLE_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define WLT_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("wlt check failed");

// next-cycle implication
`define WLT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("wlt check failed");

`endif

[design/wlt_pkg.sv]
// Shared types and constants for the wear leveling table
package wlt_pkg;
    localparam int NUM_BLOCKS = 1024;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_BAL    = 2'd2,
        REQ_STATS  = 2'd3
    } req_t;

    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_WORN = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [1:0] RC_OK     = 2'd0;
    localparam logic [1:0] RC_NONE   = 2'd1;
    localparam logic [1:0] RC_BALNCD = 2'd2;

    localparam logic [1:0] REG_WORN = 2'd0;
    localparam logic [1:0] REG_END  = 2'd1;
    localparam logic [1:0] REG_GAP  = 2'd2;

    localparam logic [31:0] WORN_RST = 32'd90000;
    localparam logic [31:0] END_RST  = 32'd100000;
    localparam logic [31:0] GAP_RST  = 32'd1000;
endpackage

[design/wlt_div.sv]
// Restoring divider: unsigned dividend by divisor, one quotient bit per cycle
module wlt_div #(
    parameter int DW = 48,
    parameter int SW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [SW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg;
    logic [SW:0]   rem_reg;
    logic [SW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [SW:0]   trial;

    always_comb
    begin
        trial = {rem_reg[SW-1:0], q_reg[DW-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
            q_reg    <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= trial - {1'b0, dvs_reg};
                q_reg   <= {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[DW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;
endmodule

[design/wear_leveling_table_core.sv]
// Top level of the wear leveling table
// Wear leveling table. A load or update transfer passes through the write state
// S_WR and then S_OUT, where its result is handed to the output register. Balance
// and statistics each scan the table once through a memory with one write port and
// one registered read port. Balance goes from the scan to S_DECIDE and, when it
// migrates, writes the two swapped entries in S_SWAP1 and S_SWAP2. Statistics ends
// with the bit-serial divide for the mean when any entry is not bad. The input is
// stalled while a request is being worked on; a finished result waits while the
// output register still holds an unclaimed one. After reset a clearing pass writes
// every entry to zero wear, good status; no item is taken meanwhile.
// Configuration writes are taken at any time over the APB port.
module wear_leveling_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [9:0]  blk_num,
    input  logic [31:0] wear_val,
    input  logic        read_ok,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_code,
    output logic        migrate,
    output logic [9:0]  hot_addr,
    output logic [9:0]  cold_addr,
    output logic [10:0] good_count,
    output logic [10:0] worn_count,
    output logic [10:0] bad_count,
    output logic [31:0] wear_lo,
    output logic [31:0] wear_hi,
    output logic [31:0] wear_mean,
    output logic [31:0] balance_total
);
    import wlt_pkg::*;

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int DW = 32 + CW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WR, S_SCAN, S_DRAIN, S_DECIDE, S_SWAP1, S_SWAP2,
        S_DIV, S_DIVWAIT, S_OUT
    } state_t;

    state_t state_reg;

    // table memory: {status, wear}
    logic [33:0] mem [NUM_BLOCKS];
    logic [33:0] rd_reg;
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [33:0] mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[mem_ra];
    end

    logic [31:0] worn_reg, end_reg, gap_reg;
    logic [31:0] bcnt_reg;
    logic [1:0]  req_reg;
    logic [AW:0] idx_reg;
    logic [31:0] wc_reg;
    logic        ok_reg;
    logic [AW:0] addr_reg;     // scan issue counter
    logic [AW:0] cmp_reg;      // index of the entry now in rd_reg
    logic        rvld_reg;
    logic        found_reg;
    logic [AW-1:0] hot_reg, cold_reg;
    logic [31:0] hw_reg, cw_reg, mn_reg, mx_reg;
    logic [CW-1:0] good_reg, worn_c_reg, bad_reg;
    logic [DW-1:0] sum_reg;
    logic [1:0]  rc_reg;
    logic        mig_reg;
    logic        ov_reg;
    logic        div_start;
    logic        div_busy;
    logic [DW-1:0] div_q;
    logic [31:0] avg_reg;

    wlt_div #(.DW(DW), .SW(CW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (good_reg + worn_c_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    logic apb_wr;
    assign apb_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WORN: prdata = worn_reg;
            REG_END:  prdata = end_reg;
            REG_GAP:  prdata = gap_reg;
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worn_reg <= WORN_RST;
            end_reg  <= END_RST;
            gap_reg  <= GAP_RST;
        end
        else if (apb_wr)
        begin
            unique case (paddr[3:2])
                REG_WORN: worn_reg <= pwdata;
                REG_END:  end_reg  <= pwdata;
                REG_GAP:  gap_reg  <= pwdata;
                default:  ;
            endcase
        end
    end

    logic [31:0] ent_w;
    logic [1:0]  ent_s;
    assign ent_w = rd_reg[31:0];
    assign ent_s = rd_reg[33:32];

    // memory port control
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = addr_reg[AW-1:0];
        mem_wd = {ST_GOOD, 32'd0};
        mem_ra = addr_reg[AW-1:0];
        unique case (state_reg)
            S_CLEAR: mem_we = 1'b1;
            S_IDLE:  mem_ra = blk_num[AW-1:0];
            S_WR:
            begin
                mem_wa = idx_reg[AW-1:0];
                mem_we = (idx_reg < (AW+1)'(NUM_BLOCKS));
                if (req_reg == REQ_LOAD)
                begin
                    if (ok_reg)
                        mem_wd = {(wc_reg > worn_reg) ? ST_WORN : ST_GOOD, wc_reg};
                    else
                        mem_wd = {ST_BAD, 32'hFFFF_FFFF};
                end
                else if (wc_reg > end_reg)
                    mem_wd = {ST_BAD, wc_reg};
                else if (wc_reg > worn_reg)
                    mem_wd = {ST_WORN, wc_reg};
                else
                    mem_wd = {ent_s, wc_reg};   // status read at acceptance stays
            end
            S_SWAP1:
            begin
                mem_we = 1'b1;
                mem_wa = hot_reg;
                mem_wd = {ST_GOOD, cw_reg};
            end
            S_SWAP2:
            begin
                mem_we = 1'b1;
                mem_wa = cold_reg;
                mem_wd = {ST_GOOD, hw_reg + 32'd1};
            end
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign div_start = (state_reg == S_DIV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            bcnt_reg  <= '0;
            ov_reg    <= 1'b0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == S_OUT && (!ov_reg || !out_stall))
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == (AW+1)'(NUM_BLOCKS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= req_type;
                        idx_reg   <= (AW+1)'(blk_num);
                        wc_reg    <= wear_val;
                        ok_reg    <= read_ok;
                        addr_reg  <= '0;
                        cmp_reg   <= '0;
                        rvld_reg  <= 1'b0;
                        found_reg <= 1'b0;
                        good_reg  <= '0;
                        worn_c_reg <= '0;
                        bad_reg   <= '0;
                        sum_reg   <= '0;
                        mn_reg    <= '0;
                        mx_reg    <= '0;
                        hot_reg   <= '0;
                        cold_reg  <= '0;
                        mig_reg   <= 1'b0;
                        rc_reg    <= RC_OK;
                        avg_reg   <= '0;
                        if (req_type == REQ_LOAD || req_type == REQ_UPDATE)
                            state_reg <= S_WR;
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_WR:
                begin
                    if (idx_reg >= (AW+1)'(NUM_BLOCKS))
                        rc_reg <= RC_NONE;
                    state_reg <= S_OUT;
                end
                S_SCAN, S_DRAIN:
                begin
                    if (state_reg == S_SCAN)
                    begin
                        addr_reg <= addr_reg + 1'b1;
                        if (addr_reg == (AW+1)'(NUM_BLOCKS - 1))
                            state_reg <= S_DRAIN;
                    end
                    rvld_reg <= (state_reg == S_SCAN);
                    if (rvld_reg)
                    begin
                        cmp_reg <= cmp_reg + 1'b1;
                        if (req_reg == REQ_BAL)
                        begin
                            if (ent_s == ST_GOOD)
                            begin
                                found_reg <= 1'b1;
                                if (!found_reg || ent_w > hw_reg)
                                begin
                                    hot_reg <= cmp_reg[AW-1:0];
                                    hw_reg  <= ent_w;
                                end
                                if (!found_reg || ent_w < cw_reg)
                                begin
                                    cold_reg <= cmp_reg[AW-1:0];
                                    cw_reg   <= ent_w;
                                end
                            end
                        end
                        else if (ent_s == ST_BAD)
                            bad_reg <= bad_reg + 1'b1;
                        else
                        begin
                            if (ent_s == ST_WORN)
                                worn_c_reg <= worn_c_reg + 1'b1;
                            else
                                good_reg <= good_reg + 1'b1;
                            found_reg <= 1'b1;
                            if (!found_reg || ent_w < mn_reg)
                                mn_reg <= ent_w;
                            if (!found_reg || ent_w > mx_reg)
                                mx_reg <= ent_w;
                            sum_reg <= sum_reg + DW'(ent_w);
                        end
                    end
                    if (state_reg == S_DRAIN && !rvld_reg && cmp_reg != '0)
                        state_reg <= (req_reg == REQ_BAL) ? S_DECIDE : S_DIV;
                end
                S_DECIDE:
                begin
                    if (!found_reg)
                    begin
                        rc_reg    <= RC_NONE;
                        state_reg <= S_OUT;
                    end
                    else if (hw_reg - cw_reg > gap_reg)
                    begin
                        mig_reg   <= 1'b1;
                        bcnt_reg  <= bcnt_reg + 32'd1;
                        state_reg <= S_SWAP1;
                    end
                    else
                    begin
                        rc_reg    <= RC_BALNCD;
                        state_reg <= S_OUT;
                    end
                end
                S_SWAP1: state_reg <= S_SWAP2;
                S_SWAP2: state_reg <= S_OUT;
                S_DIV:
                begin
                    if (!found_reg)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_DIVWAIT;
                end
                S_DIVWAIT:
                begin
                    if (!div_busy)
                    begin
                        avg_reg   <= div_q[31:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg || !out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // output register, loaded when the result is handed over
    logic [1:0]  o_rc;
    logic        o_mig;
    logic [9:0]  o_hot, o_cold;
    logic [10:0] o_good, o_worn, o_bad;
    logic [31:0] o_mn, o_mx, o_avg, o_bt;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!ov_reg || !out_stall))
        begin
            o_rc   <= rc_reg;
            o_mig  <= mig_reg;
            o_hot  <= (req_reg == REQ_BAL) ? 10'(hot_reg) : 10'd0;
            o_cold <= (req_reg == REQ_BAL) ? 10'(cold_reg) : 10'd0;
            o_good <= (req_reg == REQ_STATS) ? 11'(good_reg) : 11'd0;
            o_worn <= (req_reg == REQ_STATS) ? 11'(worn_c_reg) : 11'd0;
            o_bad  <= (req_reg == REQ_STATS) ? 11'(bad_reg) : 11'd0;
            o_mn   <= (req_reg == REQ_STATS) ? mn_reg : 32'd0;
            o_mx   <= (req_reg == REQ_STATS) ? mx_reg : 32'd0;
            o_avg  <= (req_reg == REQ_STATS) ? avg_reg : 32'd0;
            o_bt   <= bcnt_reg;
        end
    end

    assign out_valid     = ov_reg;
    assign result_code   = o_rc;
    assign migrate       = o_mig;
    assign hot_addr      = o_hot;
    assign cold_addr     = o_cold;
    assign good_count    = o_good;
    assign worn_count    = o_worn;
    assign bad_count     = o_bad;
    assign wear_lo       = o_mn;
    assign wear_hi       = o_mx;
    assign wear_mean     = o_avg;
    assign balance_total = o_bt;
endmodule

[design/wlt_checker.sv]
// Port-level checker for the wear leveling table, bound to the top level
`include "wear_leveling_table_core_macros.svh"

module wlt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  result_code,
    input logic        migrate,
    input logic [31:0] balance_total,
    input logic        pready
);
    import wlt_pkg::*;

    `WLT_ASSERT_NEXT(a_one_busy, clk, rst_n, in_valid && !in_stall, in_stall)
    `WLT_ASSERT_IMPL(a_mig_ok, clk, rst_n, out_valid && migrate, result_code == RC_OK)
    `WLT_ASSERT_IMPL(a_code_range, clk, rst_n, out_valid, result_code <= RC_BALNCD)
    `WLT_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, pready)
    `WLT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(result_code) && $stable(balance_total))
endmodule

bind wear_leveling_table_core wlt_checker u_wlt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_code   (result_code),
    .migrate       (migrate),
    .balance_total (balance_total),
    .pready        (pready)
);

[bench/tb.sv]
// Testbench for the wear leveling table: directed table then random traffic, checked by a predictor
`timescale 1ns / 100ps
module tb;
    import wlt_pkg::*;

    localparam int NBLK = NUM_BLOCKS;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [9:0]  blk_num = '0;
    logic [31:0] wear_val = '0;
    logic        read_ok = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  result_code;
    logic        migrate;
    logic [9:0]  hot_addr, cold_addr;
    logic [10:0] good_count, worn_count, bad_count;
    logic [31:0] wear_lo, wear_hi, wear_mean, balance_total;

    wear_leveling_table_core DUT (.*);

    always #5 clk = ~clk;

    typedef struct packed {
        logic [1:0]  code;
        logic        mig;
        logic [9:0]  hot;
        logic [9:0]  cold;
        logic [10:0] ngood;
        logic [10:0] nworn;
        logic [10:0] nbad;
        logic [31:0] wmin;
        logic [31:0] wmax;
        logic [31:0] wavg;
        logic [31:0] total;
    } answer_t;

    typedef struct {
        req_t        op;
        logic [9:0]  idx;
        logic [31:0] wc;
        logic        ok;
        logic        known;
        answer_t     ans;
    } row_t;

    logic [31:0] wear_tbl [NBLK];
    logic [1:0]  stat_tbl [NBLK];
    logic [31:0] mig_total;
    logic [31:0] lim_worn, lim_end, lim_gap;
    answer_t     pending_q [$];
    int          errors = 0;
    logic        hold_off = 1'b0;
    logic        free_run = 1'b0;

    function automatic answer_t predict(req_t op, logic [9:0] idx, logic [31:0] wc, logic ok);
        answer_t a;
        int      hot, cold, cnt;
        logic [63:0] sum;
        logic [31:0] t;
        a = '0;
        case (op)
            REQ_LOAD: begin
                wear_tbl[idx] = ok ? wc : 32'hFFFF_FFFF;
                stat_tbl[idx] = !ok ? ST_BAD : (wc > lim_worn ? ST_WORN : ST_GOOD);
            end
            REQ_UPDATE: begin
                wear_tbl[idx] = wc;
                if (wc > lim_end) stat_tbl[idx] = ST_BAD;
                else if (wc > lim_worn) stat_tbl[idx] = ST_WORN;
            end
            REQ_BAL: begin
                hot = -1;
                cold = -1;
                for (int i = 0; i < NBLK; i++)
                begin
                    if (stat_tbl[i] != ST_GOOD) continue;
                    if (hot < 0)
                    begin
                        hot = i;
                        cold = i;
                    end
                    else
                    begin
                        if (wear_tbl[i] > wear_tbl[hot]) hot = i;
                        if (wear_tbl[i] < wear_tbl[cold]) cold = i;
                    end
                end
                if (hot < 0) a.code = RC_NONE;
                else
                begin
                    a.hot = hot[9:0];
                    a.cold = cold[9:0];
                    if (wear_tbl[hot] - wear_tbl[cold] > lim_gap)
                    begin
                        t = wear_tbl[hot];
                        wear_tbl[hot] = wear_tbl[cold];
                        wear_tbl[cold] = t + 32'd1;
                        mig_total++;
                        a.code = RC_OK;
                        a.mig = 1'b1;
                    end
                    else a.code = RC_BALNCD;
                end
            end
            default: begin
                cnt = 0;
                sum = '0;
                for (int i = 0; i < NBLK; i++)
                begin
                    if (stat_tbl[i] == ST_BAD)
                    begin
                        a.nbad++;
                        continue;
                    end
                    if (stat_tbl[i] == ST_WORN) a.nworn++;
                    else a.ngood++;
                    if (cnt == 0 || wear_tbl[i] < a.wmin) a.wmin = wear_tbl[i];
                    if (cnt == 0 || wear_tbl[i] > a.wmax) a.wmax = wear_tbl[i];
                    sum += wear_tbl[i];
                    cnt++;
                end
                a.wavg = cnt ? 32'(sum / cnt) : '0;
            end
        endcase
        a.total = mig_total;
        return a;
    endfunction

    task automatic reg_write(logic [1:0] r, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_WORN: lim_worn = v;
            REG_END: lim_end = v;
            default: lim_gap = v;
        endcase
    endtask

    // one transfer; the prediction is queued when it is accepted
    task automatic send(req_t op, logic [9:0] idx, logic [31:0] wc, logic ok,
                        logic known = 1'b0, answer_t ans = '0);
        answer_t a;
        in_valid <= 1'b1;
        req_type <= op;
        blk_num <= idx;
        wear_val <= wc;
        read_ok <= ok;
        do @(posedge clk); while (in_stall);
        a = predict(op, idx, wc, ok);
        if (known && a != ans)
        begin
            $error("table row mismatch exp %h pred %h", ans, a);
            errors++;
        end
        pending_q.push_back(a);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // output side: random stall pattern, a free-running phase and one long hold-off
    always @(posedge clk)
    begin
        if (hold_off) out_stall <= 1'b1;
        else if (free_run) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected result");
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (result_code !== e.code) begin $error("result_code exp %0d got %0d", e.code, result_code); errors++; end
                if (migrate !== e.mig) begin $error("migrate exp %0d got %0d", e.mig, migrate); errors++; end
                if (hot_addr !== e.hot) begin $error("hot_addr exp %0d got %0d", e.hot, hot_addr); errors++; end
                if (cold_addr !== e.cold) begin $error("cold_addr exp %0d got %0d", e.cold, cold_addr); errors++; end
                if (good_count !== e.ngood) begin $error("good_count exp %0d got %0d", e.ngood, good_count); errors++; end
                if (worn_count !== e.nworn) begin $error("worn_count exp %0d got %0d", e.nworn, worn_count); errors++; end
                if (bad_count !== e.nbad) begin $error("bad_count exp %0d got %0d", e.nbad, bad_count); errors++; end
                if (wear_lo !== e.wmin) begin $error("wear_lo exp %0d got %0d", e.wmin, wear_lo); errors++; end
                if (wear_hi !== e.wmax) begin $error("wear_hi exp %0d got %0d", e.wmax, wear_hi); errors++; end
                if (wear_mean !== e.wavg) begin $error("wear_mean exp %0d got %0d", e.wavg, wear_mean); errors++; end
                if (balance_total !== e.total) begin $error("balance_total exp %0d got %0d", e.total, balance_total); errors++; end
            end
        end
    end

    function automatic answer_t stats_ans(int g, int w, int b, logic [31:0] mn,
                                          logic [31:0] mx, logic [31:0] av, logic [31:0] tot);
        answer_t a;
        a = '0;
        a.ngood = 11'(g); a.nworn = 11'(w); a.nbad = 11'(b);
        a.wmin = mn; a.wmax = mx; a.wavg = av; a.total = tot;
        return a;
    endfunction

    function automatic answer_t bal_ans(logic [1:0] c, logic m, int h, int cl, logic [31:0] tot);
        answer_t a;
        a = '0;
        a.code = c; a.mig = m; a.hot = 10'(h); a.cold = 10'(cl); a.total = tot;
        return a;
    endfunction

    initial
    begin
        row_t        rows [$];
        int          n, burst, pick;
        logic [31:0] wc;
        logic [9:0]  hot_set [8];

        for (int i = 0; i < NBLK; i++)
        begin
            wear_tbl[i] = '0;
            stat_tbl[i] = ST_GOOD;
        end
        mig_total = '0;
        lim_worn = WORN_RST;
        lim_end = END_RST;
        lim_gap = GAP_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: fresh table, extremes, bad/worn paths, migration
        rows.push_back('{REQ_STATS, 10'd0, 32'd0, 1'b0, 1'b1, stats_ans(1024, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{REQ_BAL, 10'd0, 32'd0, 1'b0, 1'b1, bal_ans(RC_BALNCD, 1'b0, 0, 0, 0)});
        rows.push_back('{REQ_LOAD, 10'd1023, 32'd5000, 1'b1, 1'b0, '0});
        rows.push_back('{REQ_BAL, 10'd0, 32'd0, 1'b0, 1'b1, bal_ans(RC_OK, 1'b1, 1023, 0, 1)});
        rows.push_back('{REQ_LOAD, 10'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0});
        rows.push_back('{REQ_LOAD, 10'd5, 32'd0, 1'b0, 1'b0, '0});
        rows.push_back('{REQ_UPDATE, 10'd6, 32'd95000, 1'b0, 1'b0, '0});
        rows.push_back('{REQ_UPDATE, 10'd7, 32'd100001, 1'b1, 1'b0, '0});
        rows.push_back('{REQ_UPDATE, 10'd8, 32'd90000, 1'b1, 1'b0, '0});
        rows.push_back('{REQ_UPDATE, 10'd9, 32'd100000, 1'b0, 1'b0, '0});
        rows.push_back('{REQ_LOAD, 10'd10, 32'd90001, 1'b1, 1'b0, '0});
        rows.push_back('{REQ_UPDATE, 10'd10, 32'd3, 1'b1, 1'b0, '0});
        rows.push_back('{REQ_STATS, 10'h3FF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0});
        rows.push_back('{REQ_BAL, 10'h155, 32'h5555_5555, 1'b1, 1'b0, '0});
        rows.push_back('{REQ_STATS, 10'h2AA, 32'hAAAA_AAAA, 1'b0, 1'b0, '0});
        foreach (rows[i])
            send(rows[i].op, rows[i].idx, rows[i].wc, rows[i].ok, rows[i].known, rows[i].ans);
        drain();

        // extreme limits: worn limit zero with gap never exceeded, then end limit and gap zero
        reg_write(REG_WORN, 32'd0);
        reg_write(REG_END, 32'hFFFF_FFFF);
        reg_write(REG_GAP, 32'hFFFF_FFFF);
        send(REQ_LOAD, 10'd20, 32'd1, 1'b1);
        send(REQ_UPDATE, 10'd21, 32'hFFFF_FFFF, 1'b1);
        send(REQ_BAL, 10'd0, 32'd0, 1'b0);
        send(REQ_STATS, 10'd0, 32'd0, 1'b0);
        drain();
        reg_write(REG_WORN, 32'hFFFF_FFFF);
        reg_write(REG_END, 32'd0);
        reg_write(REG_GAP, 32'd0);
        send(REQ_UPDATE, 10'd22, 32'd1, 1'b0);
        send(REQ_BAL, 10'd0, 32'd0, 1'b0);
        drain();

        // long receiver hold-off while loads keep coming
        hold_off <= 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        for (int i = 0; i < 40; i++)
            send(REQ_LOAD, 10'($urandom_range(100, 200)), $urandom, 1'b1);
        wait (!hold_off);
        drain();

        // random phases with different limits
        for (int ph = 0; ph < 4; ph++)
        begin
            reg_write(REG_WORN, ph == 3 ? 32'd500 : 32'd90000 + $urandom_range(0, 5000));
            reg_write(REG_END, ph == 3 ? 32'd800 : 32'd100000 + $urandom_range(0, 5000));
            reg_write(REG_GAP, ph == 2 ? 32'd0 : $urandom_range(0, 3000));
            free_run = (ph == 1);
            for (int k = 0; k < 8; k++) hot_set[k] = 10'($urandom_range(0, NBLK - 1));
            n = 0;
            while (n < 120)
            begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 120; b++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) wc = $urandom_range(0, 110000);
                    else if (pick < 55) wc = $urandom;
                    else wc = $urandom_range(0, 2000);
                    if (pick < 40)
                        send(REQ_UPDATE, hot_set[$urandom_range(0, 7)], wc, 1'($urandom));
                    else if (pick < 80)
                        send(REQ_LOAD, 10'($urandom_range(0, NBLK - 1)), wc,
                             $urandom_range(0, 9) != 0);
                    else if (pick < 93)
                        send(REQ_BAL, 10'($urandom), $urandom, 1'($urandom));
                    else
                        send(REQ_STATS, 10'($urandom), $urandom, 1'($urandom));
                    n++;
                end
                if ($urandom_range(0, 2) != 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("PASS wear_leveling_table_core");
        else
            $display("FAIL wear_leveling_table_core");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("FAIL wear_leveling_table_core");
        $finish;
    end
endmodule
